### rtl/jsfe_pkg.sv
// Shared types, constants and codes for the JSON string field extractor.
`timescale 1ns / 1ps
package jsfe_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int SEEN_W        = $clog2(MAX_KEY_BYTES + 1);
    localparam int MAX_RESULTS   = 4;
    localparam int RES_IDX_W     = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int KEY_LEN_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_AFTER_KEY,
        PH_AFTER_COLON,
        PH_STRING,
        PH_ESCAPE,
        PH_HEX,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       run_last;
    } t_result;

    // Results caused by one input transaction, slot 0 first.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]      cnt;
    } t_group;

endpackage

### rtl/jsfe_if.sv
// Valid/ready channel interfaces for document bytes and result items.
`timescale 1ns / 1ps
interface jsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       doc_end;

    modport source(output valid, in_byte, doc_end, input ready);
    modport sink(input valid, in_byte, doc_end, output ready);
endinterface

interface jsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;

    modport source(output valid, out_byte, kind, run_last, input ready);
    modport sink(input valid, out_byte, kind, run_last, output ready);
endinterface

### rtl/jsfe_cell.sv
// One window cell: holds a recent byte and compares its incoming byte with the key.
`timescale 1ns / 1ps
module jsfe_cell
    import jsfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic       i_active,
    output logic [7:0] o_byte,
    output logic       o_ok
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // compare against the value being shifted in this cycle
    assign o_ok   = !i_active || (i_byte == i_pat);
    assign o_byte = r_byte;

endmodule

### rtl/jsfe_parser.sv
// Separator checks, escape and \u decoding; builds the result group per byte.
`timescale 1ns / 1ps
module jsfe_parser
    import jsfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_match,
    output logic       o_searching,
    output t_group     o_grp
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_acc, n_acc;
    logic [15:0] w_cp;
    logic [4:0]  w_hv;
    t_group      grp;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_hex   <= '0;
            r_acc   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_acc   <= n_acc;
        end
    end

    assign w_hv = hex_val(i_byte);
    assign w_cp = {r_acc[11:0], w_hv[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_acc   = r_acc;
        grp     = '0;
        unique case (r_phase)
            PH_SEARCH: begin
                if (i_match) begin
                    n_phase = PH_AFTER_KEY;
                end
            end
            PH_AFTER_KEY: begin
                if (i_byte == CH_COLON) begin
                    n_phase = PH_AFTER_COLON;
                end else if (!is_ws(i_byte)) begin
                    grp.res[0].kind     = KIND_FAIL;
                    grp.res[0].run_last = 1'b1;
                    grp.cnt             = 3'd1;
                    n_phase             = PH_DONE;
                end
            end
            PH_AFTER_COLON: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase = PH_STRING;
                end else if (!is_ws(i_byte)) begin
                    grp.res[0].kind     = KIND_FAIL;
                    grp.res[0].run_last = 1'b1;
                    grp.cnt             = 3'd1;
                    n_phase             = PH_DONE;
                end
            end
            PH_STRING: begin
                if (i_byte == CH_QUOTE) begin
                    grp.res[0].kind     = KIND_FOUND;
                    grp.res[0].run_last = 1'b1;
                    grp.cnt             = 3'd1;
                    n_phase             = PH_DONE;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    grp.res[0].out_byte = i_byte;
                    grp.cnt             = 3'd1;
                end
            end
            PH_ESCAPE: begin
                n_phase = PH_STRING;
                grp.cnt = 3'd1;
                priority case (i_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: grp.res[0].out_byte = i_byte;
                    CH_LOW_B: grp.res[0].out_byte = 8'h08;
                    CH_LOW_F: grp.res[0].out_byte = 8'h0C;
                    CH_LOW_N: grp.res[0].out_byte = 8'h0A;
                    CH_LOW_R: grp.res[0].out_byte = 8'h0D;
                    CH_LOW_T: grp.res[0].out_byte = 8'h09;
                    CH_LOW_U: begin
                        grp.cnt = 3'd0;
                        n_phase = PH_HEX;
                        n_hex   = '0;
                        n_acc   = '0;
                    end
                    default: begin
                        grp.res[0].kind     = KIND_FAIL;
                        grp.res[0].run_last = 1'b1;
                        n_phase             = PH_DONE;
                    end
                endcase
            end
            PH_HEX: begin
                if (!w_hv[4]) begin
                    grp.res[0].kind     = KIND_FAIL;
                    grp.res[0].run_last = 1'b1;
                    grp.cnt             = 3'd1;
                    n_phase             = PH_DONE;
                end else begin
                    n_acc = w_cp;
                    if (r_hex != 2'd3) begin
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_hex   = '0;
                        n_phase = PH_STRING;
                        if (w_cp <= 16'h007F) begin
                            grp.res[0].out_byte = w_cp[7:0];
                            grp.cnt             = 3'd1;
                        end else if (w_cp <= 16'h07FF) begin
                            grp.res[0].out_byte = 8'hC0 | {3'b000, w_cp[10:6]};
                            grp.res[1].out_byte = 8'h80 | {2'b00, w_cp[5:0]};
                            grp.cnt             = 3'd2;
                        end else begin
                            grp.res[0].out_byte = 8'hE0 | {4'h0, w_cp[15:12]};
                            grp.res[1].out_byte = 8'h80 | {2'b00, w_cp[11:6]};
                            grp.res[2].out_byte = 8'h80 | {2'b00, w_cp[5:0]};
                            grp.cnt             = 3'd3;
                        end
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // document end: fail status unless one was already given, then clear
        if (i_end) begin
            if (n_phase != PH_DONE) begin
                grp.res[grp.cnt[RES_IDX_W-1:0]].kind     = KIND_FAIL;
                grp.res[grp.cnt[RES_IDX_W-1:0]].run_last = 1'b1;
                grp.cnt = grp.cnt + 3'd1;
            end
            n_phase = PH_SEARCH;
            n_hex   = '0;
            n_acc   = '0;
        end
    end

    assign o_searching = (r_phase == PH_SEARCH);
    assign o_grp       = grp;

    default clocking cb @(posedge i_clk); endclocking
    default disable iff (!i_rst_n);

    a_end_clears: assert property ((i_take && i_end) |=> (r_phase == PH_SEARCH))
        else $error("phase not cleared after document end");
    a_done_silent: assert property ((i_take && !i_end && r_phase == PH_DONE)
        |-> (grp.cnt == '0))
        else $error("results produced after status");

endmodule

### rtl/jsfe_queue.sv
// Two-entry queue of result groups, unloaded one result per output transaction.
`timescale 1ns / 1ps
module jsfe_queue
    import jsfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_group            i_grp,
    output logic              o_full,
    jsfe_out_if.source        o_out
);

    t_group               r_mem [2];
    logic                 r_wptr;
    logic                 r_rptr;
    logic [1:0]           r_count;
    logic [RES_IDX_W-1:0] r_idx;
    t_group               w_head;
    t_result              w_res;
    logic                 w_hs;
    logic                 w_pop;

    assign w_head = r_mem[r_rptr];
    assign w_res  = w_head.res[r_idx];
    assign w_hs   = o_out.valid && o_out.ready;
    assign w_pop  = w_hs && ({1'b0, r_idx} == (w_head.cnt - 3'd1));
    assign o_full = (r_count == 2'd2);

    assign o_out.valid    = (r_count != 2'd0);
    assign o_out.out_byte = w_res.out_byte;
    assign o_out.kind     = w_res.kind;
    assign o_out.run_last = w_res.run_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
                r_idx  <= '0;
            end else if (w_hs) begin
                r_idx <= r_idx + 2'd1;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    default clocking cb @(posedge i_clk); endclocking
    default disable iff (!i_rst_n);

    a_no_overflow: assert property (i_push |-> (r_count != 2'd2))
        else $error("group pushed into full queue");
    a_group_size: assert property (i_push |-> (i_grp.cnt != '0 && i_grp.cnt <= 3'd4))
        else $error("empty or oversized group pushed");
    a_idx_in_group: assert property ((r_count != 2'd0) |-> ({1'b0, r_idx} < w_head.cnt))
        else $error("result index beyond group");
    a_pop_restart: assert property (w_pop |=> (r_idx == '0))
        else $error("index not restarted after group");

endmodule

### rtl/json_string_field_extractor.sv
// Top level: key window cells, value parser, result queue and config registers.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    in_byte[7:0], doc_end
//  o_out     out  valid/ready    out_byte[7:0], kind[1:0], run_last
//  i_cfg_*   in   write enable   i_cfg_idx[1:0], i_cfg_data[63:0]
//
// One document byte per cycle while the queue is not full; the 16-cell window compare
// and the phase update complete in the accepting cycle. Each byte yields up to four results,
// sent one per cycle while o_out.ready is high from a two-group queue; i_in.ready drops only while it is full.
// Results are registered in the queue before they appear on o_out.
// Reset is synchronous, active low, and resets the config registers (key length to 1) and document state.
`timescale 1ns / 1ps
module json_string_field_extractor
    import jsfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jsfe_in_if.sink               i_in,
    jsfe_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0]        r_key_low;
    logic [CFG_DATA_W-1:0]        r_key_high;
    logic [KEY_LEN_W-1:0]         r_key_len;
    logic [SEEN_W-1:0]            r_seen;
    logic [SEEN_W-1:0]            n_seen;
    logic [KEY_LEN_W-1:0]         w_klim;
    logic [2*CFG_DATA_W-1:0]      w_key;
    logic [7:0]                   w_byte [MAX_KEY_BYTES];
    logic [MAX_KEY_BYTES-1:0]     w_ok;
    logic                         w_take;
    logic                         w_shift;
    logic                         w_clear;
    logic                         w_match;
    logic                         w_searching;
    logic                         w_full;
    t_group                       w_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_key_len == '0) begin
            w_klim = KEY_LEN_W'(1);
        end else if (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            w_klim = KEY_LEN_W'(MAX_KEY_BYTES);
        end else begin
            w_klim = r_key_len;
        end
    end

    assign w_key   = {r_key_high, r_key_low};
    assign w_take  = i_in.valid && i_in.ready;
    assign w_shift = w_take && w_searching;
    assign w_clear = w_take && i_in.doc_end;
    assign n_seen  = (r_seen < SEEN_W'(MAX_KEY_BYTES)) ? r_seen + SEEN_W'(1) : r_seen;
    assign w_match = w_searching && (&w_ok) && (KEY_LEN_W'(n_seen) >= w_klim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_seen <= '0;
        end else if (w_shift) begin
            r_seen <= n_seen;
        end
    end

    // cell j holds the byte seen j+1 bytes ago; its incoming byte meets key byte klim-1-j
    for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_cell
        logic [KEY_IDX_W-1:0] w_pidx;
        logic [7:0]           w_in;

        assign w_pidx = KEY_IDX_W'(w_klim - KEY_LEN_W'(j) - KEY_LEN_W'(1));

        if (j == 0) begin : g_head
            assign w_in = i_in.in_byte;
        end else begin : g_link
            assign w_in = w_byte[j-1];
        end

        jsfe_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_clear  (w_clear),
            .i_byte   (w_in),
            .i_pat    (w_key[w_pidx*8 +: 8]),
            .i_active (KEY_LEN_W'(j) < w_klim),
            .o_byte   (w_byte[j]),
            .o_ok     (w_ok[j])
        );
    end

    jsfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_byte      (i_in.in_byte),
        .i_end       (i_in.doc_end),
        .i_match     (w_match),
        .o_searching (w_searching),
        .o_grp       (w_grp)
    );

    jsfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take && (w_grp.cnt != '0)),
        .i_grp   (w_grp),
        .o_full  (w_full),
        .o_out   (o_out)
    );

    assign i_in.ready = !w_full;

endmodule
